/* rtl/gcd_pkg.sv */
// ----------------------------------------------------------------------------
// gcd_pkg
// shared widths, fixed-point types and elaboration-time cordic tables for the
// great circle distance pipeline
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int FRAC_BITS = 24;
  localparam int CW        = FRAC_BITS + 4;   // signed fixed-point word
  localparam int MW        = CW - 1;          // magnitude of a fixed-point word

  typedef logic signed [CW-1:0] fix_t;

  // angle reduction
  localparam int TW      = 29;                // angle in hundredths of a second
  localparam int RW      = 25;                // remainder inside one quadrant
  localparam int CLO_W   = 31;
  localparam int CHI_W   = 33;
  localparam int ZSH     = 86 - FRAC_BITS;
  localparam int FULL_W  = ZSH + CW;

  localparam longint CSEC_PER_DEG = 360000;
  localparam longint CSEC_PER_MIN = 6000;
  localparam longint CSEC_TURN    = 129600000;
  localparam longint CSEC_QUARTER = 32400000;
  localparam longint CSEC_EIGHTH  = 16200000;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_t;

  // square root
  localparam int SQ_W = FRAC_BITS + 2;        // radicand 1 +/- d
  localparam int RT_W = FRAC_BITS + 1;        // root

  // distance
  localparam int     RAD_W        = 16;
  localparam int     RAD10_W      = 20;
  localparam int     DIST_W       = 21;
  localparam longint DKM_PER_KM   = 10;
  localparam longint OUT_MAX      = 2097151;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd6378;

  // ports
  localparam int IN_W   = 112;
  localparam int ANG_W  = 28;
  localparam int OUT_W  = 24;
  localparam int ADDR_W = 2;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-1:0] ADDR_RADIUS = 2'd0;

  // long division, quotient truncated to 64 bits
  function automatic logic [63:0] udiv128(input logic [127:0] a, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    if (d != 64'd0) begin
      for (int i = 127; i >= 0; i--) begin
        r = {r[63:0], a[i]};
        q = {q[62:0], 1'b0};
        if (r >= {1'b0, d}) begin
          r = r - {1'b0, d};
          q[0] = 1'b1;
        end
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] d);
    return udiv128({64'd0, a}, d);
  endfunction

  function automatic logic [63:0] atan_inv62(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    p   = udiv(64'd1 << 62, n);
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        t   = udiv(p, 64'(2 * k + 1));
        sum = k[0] ? sum - t : sum + t;
        p   = udiv(p, n * n);
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] to_frac(input logic [63:0] v);
    return (v + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
  endfunction

  function automatic logic [63:0] pi4_62();
    return 64'd4 * atan_inv62(64'd5) - atan_inv62(64'd239);
  endfunction

  function automatic logic [63:0] atan_frac(input int i);
    logic [63:0] sum;
    logic [63:0] t;
    sum = '0;
    if (i == 0) begin
      sum = pi4_62();
    end else begin
      for (int k = 0; k < 32; k++) begin
        if (i * (2 * k + 1) <= 62) begin
          t   = udiv(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
          sum = k[0] ? sum - t : sum + t;
        end
      end
    end
    return to_frac(sum);
  endfunction

  function automatic logic [63:0] gain_frac();
    logic [63:0]  k2;
    logic [127:0] num;
    logic [127:0] res;
    logic [127:0] bitv;
    k2 = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (i < FRAC_BITS) k2 = k2 - udiv(k2, (64'd1 << (2 * i)) + 64'd1);
    end
    num  = {2'b00, k2, 62'd0};
    res  = '0;
    bitv = 128'd1 << 126;
    for (int j = 0; j < 64; j++) begin
      if (num >= res + bitv) begin
        num = num - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return to_frac(res[63:0]);
  endfunction

  function automatic logic [63:0] rad_per_csec();
    return udiv128({40'd0, pi4_62(), 24'd0}, 64'(CSEC_EIGHTH));
  endfunction

  localparam logic [63:0] RAD_PER_CSEC = rad_per_csec();
  localparam logic [63:0] GAIN_F       = gain_frac();

endpackage

/* rtl/gcd_cos_sin.sv */
// ----------------------------------------------------------------------------
// gcd_cos_sin
// pipelined angle reduction and rotation-mode cordic, one angle per cycle while en is high
// ----------------------------------------------------------------------------
module gcd_cos_sin (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [8:0]    deg,
  input  logic [5:0]           arc_min,
  input  logic [12:0]          csec,
  output gcd_pkg::fix_t        cos_val,
  output gcd_pkg::fix_t        sin_val
);
  import gcd_pkg::*;

  localparam logic signed [TW-1:0] T_DEG  = TW'(CSEC_PER_DEG);
  localparam logic signed [TW-1:0] T_MIN  = TW'(CSEC_PER_MIN);
  localparam logic signed [TW-1:0] T_TURN = TW'(CSEC_TURN);
  localparam logic [TW-2:0] Q1 = (TW-1)'(CSEC_QUARTER);
  localparam logic [TW-2:0] Q2 = (TW-1)'(2 * CSEC_QUARTER);
  localparam logic [TW-2:0] Q3 = (TW-1)'(3 * CSEC_QUARTER);
  localparam logic [CLO_W-1:0] C_LO = RAD_PER_CSEC[CLO_W-1:0];
  localparam logic [CHI_W-1:0] C_HI = RAD_PER_CSEC[CLO_W +: CHI_W];
  localparam logic [FULL_W-1:0] Z_RND = FULL_W'(1) << (ZSH - 1);

  // stage 1: angle in hundredths of a second
  logic signed [TW-1:0] t1;
  // stage 2: quadrant and remainder
  quad_t                q2;
  logic [RW-1:0]        r2;
  // stage 3: partial products of remainder times radians per csec
  quad_t                q3;
  logic [RW+CLO_W-1:0]  pp_lo;
  logic [RW+CHI_W-1:0]  pp_hi;
  // stage 4: residual angle in radians
  quad_t                q4;
  fix_t                 z4;

  logic [TW-2:0]        m_wrap;
  logic signed [TW-1:0] t_wrap;
  logic [FULL_W-1:0]    full;

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= $signed({{(TW-9){deg[8]}}, deg}) * T_DEG
          + $signed(TW'(arc_min)) * T_MIN
          + $signed(TW'(csec));
    end
  end

  always_comb begin
    t_wrap = t1[TW-1] ? t1 + T_TURN : t1;
    m_wrap = t_wrap[TW-2:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (m_wrap >= Q3) begin
        q2 <= QUAD_270;
        r2 <= RW'(m_wrap - Q3);
      end else if (m_wrap >= Q2) begin
        q2 <= QUAD_180;
        r2 <= RW'(m_wrap - Q2);
      end else if (m_wrap >= Q1) begin
        q2 <= QUAD_90;
        r2 <= RW'(m_wrap - Q1);
      end else begin
        q2 <= QUAD_0;
        r2 <= RW'(m_wrap);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q3    <= q2;
      pp_lo <= r2 * C_LO;
      pp_hi <= r2 * C_HI;
    end
  end

  assign full = FULL_W'({pp_hi, {CLO_W{1'b0}}}) + FULL_W'(pp_lo) + Z_RND;

  always_ff @(posedge clk) begin
    if (en) begin
      q4 <= q3;
      z4 <= $signed(full[ZSH +: CW]);
    end
  end

  // cordic iterations, one per stage
  fix_t  xs [1:FRAC_BITS];
  fix_t  ys [1:FRAC_BITS];
  fix_t  zs [1:FRAC_BITS];
  quad_t qs [1:FRAC_BITS];

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_rot
    localparam fix_t ATN = fix_t'(atan_frac(i));
    fix_t  xin;
    fix_t  yin;
    fix_t  zin;
    quad_t qin;
    if (i == 0) begin : g_first
      assign xin = fix_t'(GAIN_F);
      assign yin = '0;
      assign zin = z4;
      assign qin = q4;
    end else begin : g_next
      assign xin = xs[i];
      assign yin = ys[i];
      assign zin = zs[i];
      assign qin = qs[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        qs[i+1] <= qin;
        if (!zin[CW-1]) begin
          xs[i+1] <= xin - (yin >>> i);
          ys[i+1] <= yin + (xin >>> i);
          zs[i+1] <= zin - ATN;
        end else begin
          xs[i+1] <= xin + (yin >>> i);
          ys[i+1] <= yin - (xin >>> i);
          zs[i+1] <= zin + ATN;
        end
      end
    end
  end

  // whole quarter turns applied exactly
  always_comb begin
    unique case (qs[FRAC_BITS])
      QUAD_0: begin
        cos_val = xs[FRAC_BITS];
        sin_val = ys[FRAC_BITS];
      end
      QUAD_90: begin
        cos_val = -ys[FRAC_BITS];
        sin_val = xs[FRAC_BITS];
      end
      QUAD_180: begin
        cos_val = -xs[FRAC_BITS];
        sin_val = -ys[FRAC_BITS];
      end
      QUAD_270: begin
        cos_val = ys[FRAC_BITS];
        sin_val = -xs[FRAC_BITS];
      end
    endcase
  end

endmodule

/* rtl/gcd_isqrt.sv */
// ----------------------------------------------------------------------------
// gcd_isqrt
// pipelined floor square root of radicand * 2^FRAC_BITS, one root bit a stage
// ----------------------------------------------------------------------------
module gcd_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [gcd_pkg::SQ_W-1:0]   radicand,
  output logic [gcd_pkg::RT_W-1:0]   root
);
  import gcd_pkg::*;

  localparam int NW = SQ_W + FRAC_BITS;
  localparam int S  = FRAC_BITS + 1;

  logic [NW:0] num [1:S];
  logic [NW:0] res [1:S];

  for (genvar k = 0; k < S; k++) begin : g_bit
    localparam logic [NW:0] BITV = (NW+1)'(1) << (2 * (FRAC_BITS - k));
    logic [NW:0] num_in;
    logic [NW:0] res_in;
    logic [NW:0] trial;
    if (k == 0) begin : g_first
      assign num_in = {1'b0, radicand, {FRAC_BITS{1'b0}}};
      assign res_in = '0;
    end else begin : g_next
      assign num_in = num[k];
      assign res_in = res[k];
    end
    assign trial = res_in + BITV;
    always_ff @(posedge clk) begin
      if (en) begin
        if (num_in >= trial) begin
          num[k+1] <= num_in - trial;
          res[k+1] <= (res_in >> 1) + BITV;
        end else begin
          num[k+1] <= num_in;
          res[k+1] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res[S][RT_W-1:0];

endmodule

/* rtl/great_circle_distance.sv */
// ----------------------------------------------------------------------------
// great_circle_distance
// arc length between two points given in degrees, minutes and hundredths of
// seconds, by the spherical law of cosines on fixed-point cordic hardware
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                   carries
//  s_*       in         s_tvalid / s_tready         two points, 112-bit tdata
//  m_*       out        m_tvalid / m_tready         distance in 0.1 km, 24-bit
//  apb       in         psel / penable / pready     sphere_radius_km at 0x0
//
//  one request enters per cycle while the output buffer has room; a result leaves
//  after passing the two cordic chains and the root stages
//  every stage advances together; the pipeline holds only while the two-entry
//  output buffer is full, so a waiting result does not block new requests
//  rst is synchronous: it clears the valid bits, the output buffer and sets the
//  radius back to 6378 km; data registers are not reset
//  the radius is read at the final multiply, so write it only when idle
//
module great_circle_distance (
  input  logic                          clk,
  input  logic                          rst,
  // stream in
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // from_lat_deg[8:0] from_lat_min[14:9] from_lat_csec[27:15]
  // from_lon_deg[36:28] from_lon_min[42:37] from_lon_csec[55:43]
  // to_lat_deg[64:56] to_lat_min[70:65] to_lat_csec[83:71]
  // to_lon_deg[92:84] to_lon_min[98:93] to_lon_csec[111:99]
  input  logic [gcd_pkg::IN_W-1:0]      s_tdata,
  // stream out
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // distance_dkm[20:0], zero above
  output logic [gcd_pkg::OUT_W-1:0]     m_tdata,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gcd_pkg::ADDR_W-1:0]    paddr,
  input  logic [gcd_pkg::DATA_W-1:0]    pwdata,
  output logic [gcd_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import gcd_pkg::*;

  localparam int CS_LAT = 4 + FRAC_BITS;
  localparam int TOTAL  = CS_LAT + 5 + (FRAC_BITS + 1) + FRAC_BITS + 2;
  localparam fix_t ONE       = fix_t'(64'd1 << FRAC_BITS);
  localparam fix_t NEG_ONE   = -ONE;
  localparam logic [2*MW-1:0] P_HALF = (2*MW)'(1) << (FRAC_BITS - 1);
  localparam int DP_W = CW + RAD10_W;
  localparam logic [DP_W-1:0] D_HALF = DP_W'(1) << (FRAC_BITS - 1);
  localparam logic [DP_W-FRAC_BITS-1:0] D_MAX = (DP_W-FRAC_BITS)'(OUT_MAX);

  // --- configuration register ---
  logic [RAD_W-1:0]   radius;
  logic [RAD10_W-1:0] rad10;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_RADIUS) begin
      radius <= pwdata[RAD_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_RADIUS) ? DATA_W'(radius) : '0;
  assign rad10  = RAD10_W'(radius) * RAD10_W'(DKM_PER_KM);

  // --- flow control ---
  logic [1:0]        cnt;        // output buffer fill
  logic              en;         // whole pipeline advances
  logic [TOTAL-1:0]  vld;
  logic              push;
  logic              pop;
  logic [DIST_W-1:0] buf0;
  logic [DIST_W-1:0] buf1;
  logic [DIST_W-1:0] r_dist;

  assign en       = (cnt != 2'd2);
  assign s_tready = en;
  assign push     = en && vld[TOTAL-1];
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = OUT_W'(buf0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (push && !pop) begin
      cnt <= cnt + 2'd1;
    end else if (pop && !push) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt == 2'd1) begin
        buf0 <= r_dist;
      end else begin
        buf0 <= buf1;
        buf1 <= r_dist;
      end
    end else if (pop) begin
      buf0 <= buf1;
    end else if (push) begin
      if (cnt == 2'd0) buf0 <= r_dist;
      else buf1 <= r_dist;
    end
  end

  // --- cos and sin of the four angles: from lat, from lon, to lat, to lon ---
  fix_t cs_cos [4];
  fix_t cs_sin [4];

  for (genvar a = 0; a < 4; a++) begin : g_ang
    gcd_cos_sin u_cs (
      .clk     (clk),
      .en      (en),
      .deg     ($signed(s_tdata[a*ANG_W +: 9])),
      .arc_min (s_tdata[a*ANG_W+9 +: 6]),
      .csec    (s_tdata[a*ANG_W+15 +: 13]),
      .cos_val (cs_cos[a]),
      .sin_val (cs_sin[a])
    );
  end

  function automatic logic [MW-1:0] mag(input fix_t v);
    return v[CW-1] ? MW'(-v) : MW'(v);
  endfunction

  // rounded fixed-point product, halves away from zero
  function automatic fix_t fround(input logic [2*MW-1:0] prod, input logic neg);
    logic [2*MW-1:0] s;
    fix_t m;
    s = prod + P_HALF;
    m = $signed({1'b0, s[FRAC_BITS +: MW]});
    return neg ? -m : m;
  endfunction

  // --- unit vectors ---
  logic [2*MW-1:0] p1_prod [4];
  logic            p1_neg  [4];
  fix_t            p1_slat [2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 2; p++) begin
        p1_prod[2*p]   <= mag(cs_cos[2*p]) * mag(cs_cos[2*p+1]);
        p1_neg[2*p]    <= cs_cos[2*p][CW-1] ^ cs_cos[2*p+1][CW-1];
        p1_prod[2*p+1] <= mag(cs_cos[2*p]) * mag(cs_sin[2*p+1]);
        p1_neg[2*p+1]  <= cs_cos[2*p][CW-1] ^ cs_sin[2*p+1][CW-1];
        p1_slat[p]     <= cs_sin[2*p];
      end
    end
  end

  fix_t va [3];
  fix_t vb [3];

  always_ff @(posedge clk) begin
    if (en) begin
      va[0] <= fround(p1_prod[0], p1_neg[0]);
      va[1] <= fround(p1_prod[1], p1_neg[1]);
      va[2] <= p1_slat[0];
      vb[0] <= fround(p1_prod[2], p1_neg[2]);
      vb[1] <= fround(p1_prod[3], p1_neg[3]);
      vb[2] <= p1_slat[1];
    end
  end

  // --- dot product ---
  logic [2*MW-1:0] p3_prod [3];
  logic            p3_neg  [3];
  fix_t            p4_dot;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        p3_prod[j] <= mag(va[j]) * mag(vb[j]);
        p3_neg[j]  <= va[j][CW-1] ^ vb[j][CW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_dot <= fround(p3_prod[0], p3_neg[0]) + fround(p3_prod[1], p3_neg[1])
              + fround(p3_prod[2], p3_neg[2]);
    end
  end

  // --- clamp and form 1+d, 1-d ---
  fix_t            dot_c;
  fix_t            sum_x;
  fix_t            sum_y;
  logic [SQ_W-1:0] p5_x;
  logic [SQ_W-1:0] p5_y;

  always_comb begin
    if (p4_dot > ONE) dot_c = ONE;
    else if (p4_dot < NEG_ONE) dot_c = NEG_ONE;
    else dot_c = p4_dot;
    sum_x = ONE + dot_c;
    sum_y = ONE - dot_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p5_x <= SQ_W'(sum_x);
      p5_y <= SQ_W'(sum_y);
    end
  end

  logic [RT_W-1:0] rt_x;
  logic [RT_W-1:0] rt_y;

  gcd_isqrt u_sqrt_x (
    .clk      (clk),
    .en       (en),
    .radicand (p5_x),
    .root     (rt_x)
  );

  gcd_isqrt u_sqrt_y (
    .clk      (clk),
    .en       (en),
    .radicand (p5_y),
    .root     (rt_y)
  );

  // --- vectoring cordic: half the central angle ---
  fix_t vx [1:FRAC_BITS];
  fix_t vy [1:FRAC_BITS];
  fix_t vz [1:FRAC_BITS];

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_vec
    localparam fix_t ATN = fix_t'(atan_frac(i));
    fix_t xin;
    fix_t yin;
    fix_t zin;
    if (i == 0) begin : g_first
      assign xin = $signed(CW'(rt_x));
      assign yin = $signed(CW'(rt_y));
      assign zin = '0;
    end else begin : g_next
      assign xin = vx[i];
      assign yin = vy[i];
      assign zin = vz[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!yin[CW-1]) begin
          vx[i+1] <= xin + (yin >>> i);
          vy[i+1] <= yin - (xin >>> i);
          vz[i+1] <= zin + ATN;
        end else begin
          vx[i+1] <= xin - (yin >>> i);
          vy[i+1] <= yin + (xin >>> i);
          vz[i+1] <= zin - ATN;
        end
      end
    end
  end

  // --- scale by radius, round, saturate ---
  logic [CW-1:0]             theta;
  logic [DP_W-1:0]           m_prod;
  logic [DP_W-1:0]           d_sum;
  logic [DP_W-FRAC_BITS-1:0] d_full;

  assign theta = vz[FRAC_BITS][CW-1] ? '0 : {vz[FRAC_BITS][CW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      m_prod <= theta * rad10;
    end
  end

  assign d_sum  = m_prod + D_HALF;
  assign d_full = d_sum[DP_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      r_dist <= (d_full > D_MAX) ? DIST_W'(OUT_MAX) : DIST_W'(d_full);
    end
  end

endmodule
